// File: rtl/irk_pkg.sv
package irk_pkg;

    // Input commands.
    localparam logic [1:0] CMD_FRAME  = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_MAP_WR = 2'd2;

    // Protocol modes. The spare code behaves as NEC.
    localparam logic [1:0] MODE_NEC     = 2'd0;
    localparam logic [1:0] MODE_RCA     = 2'd1;
    localparam logic [1:0] MODE_TOSHIBA = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE          = 2'd0;
    localparam logic [1:0] REG_CUSTOMER      = 2'd1;
    localparam logic [1:0] REG_REPEAT_HOLD   = 2'd2;
    localparam logic [1:0] REG_RELEASE_DELAY = 2'd3;

    // Event kinds.
    localparam logic KIND_DOWN = 1'b0;
    localparam logic KIND_UP   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_REPEAT_HOLD   = 16'd200;
    localparam logic [7:0]  RST_RELEASE_DELAY = 8'd7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        repeat_bit;
        logic [31:0] frame_word;
        logic [5:0]  map_index;
        logic [7:0]  map_scan;
        logic [15:0] map_key;
    } t_in_item;

    typedef struct packed {
        logic        event_kind;
        logic [15:0] customer_field;
        logic [7:0]  scan_field;
        logic [15:0] mapped_key;
        logic        mapped_valid;
        logic        repeat_flag;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic decide;
        logic search_start;
        logic search_step;
        logic load_out;
        logic next_event;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [1:0] ev_count;
        logic       search_done;
        logic       has_more;
        logic       out_free;
    } t_dp_status;

endpackage

// File: rtl/irk_ctrl.sv
module irk_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  irk_pkg::t_dp_status i_status,
    output irk_pkg::t_ctrl_cmd  o_cmd
);
    import irk_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SEARCH,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_status.ev_count != 2'd0) begin
                    o_cmd.search_start = 1'b1;
                    n_state            = S_SEARCH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_status.search_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_status.has_more) begin
                        o_cmd.next_event   = 1'b1;
                        o_cmd.search_start = 1'b1;
                        n_state            = S_SEARCH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/irk_dp.sv
module irk_dp #(
    parameter int MAP_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  irk_pkg::t_in_item   i_in_data,
    input  irk_pkg::t_ctrl_cmd  i_cmd,
    output irk_pkg::t_dp_status o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output irk_pkg::t_out_item  o_out_data
);
    import irk_pkg::*;

    localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int IW = 9;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_DEPTH - 1);
    localparam logic [IW-1:0] DEPTH_LIM = IW'(MAP_DEPTH);

    // Configuration.
    logic [1:0]  r_mode;
    logic [15:0] r_cust;
    logic [15:0] r_hold;
    logic [7:0]  r_rdelay;

    // Captured input item.
    t_in_item r_in;

    // Key map: scan code in the upper byte, key code below.
    logic [23:0]          r_mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] r_map_vld;

    // Event tracking state.
    logic [31:0] r_tick;
    logic [1:0]  r_rep_cnt;
    logic [31:0] r_frt;
    logic [31:0] r_held;
    logic        r_kd;
    logic [7:0]  r_rel_cnt;
    logic        r_rel_armed;

    // Pending events of the current item.
    logic [31:0] r_ev0_word;
    logic        r_ev0_kind;
    logic        r_ev0_rep;
    logic [31:0] r_ev1_word;
    logic [1:0]  r_ev_n;
    logic        r_ev_sel;

    // Search pipeline.
    logic [AW-1:0] r_addr;
    logic          r_issue_done;
    logic          r_pipe;
    logic          r_pipe_last;
    logic [23:0]   r_rd_word;
    logic          r_rd_vld;
    logic [15:0]   r_res_key;
    logic          r_res_hit;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;

    // Next-state values for one item.
    logic [31:0] n_tick;
    logic [1:0]  n_rep_cnt;
    logic [31:0] n_frt;
    logic [31:0] n_held;
    logic        n_kd;
    logic [7:0]  n_rel_cnt;
    logic        n_rel_armed;
    logic [31:0] n_ev0_word;
    logic        n_ev0_kind;
    logic        n_ev0_rep;
    logic [1:0]  n_ev_n;

    logic [1:0]  rc1;
    logic [31:0] frt1;
    logic [31:0] delta;
    logic        fire;
    logic        up;
    logic        kd1;

    logic [31:0] cur_word;
    logic        cur_kind;
    logic        cur_rep;
    logic [15:0] cur_cust;
    logic [7:0]  cur_scan;
    logic        cust_match;
    logic        match;
    logic        map_we;
    logic        rd_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NEC;
            r_cust   <= '0;
            r_hold   <= RST_REPEAT_HOLD;
            r_rdelay <= RST_RELEASE_DELAY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE:          r_mode   <= i_cfg_data[1:0];
                REG_CUSTOMER:      r_cust   <= i_cfg_data;
                REG_REPEAT_HOLD:   r_hold   <= i_cfg_data;
                REG_RELEASE_DELAY: r_rdelay <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
    end

    always_comb begin
        n_tick      = r_tick;
        n_rep_cnt   = r_rep_cnt;
        n_frt       = r_frt;
        n_held      = r_held;
        n_kd        = r_kd;
        n_rel_cnt   = r_rel_cnt;
        n_rel_armed = r_rel_armed;
        n_ev0_word  = r_in.frame_word;
        n_ev0_kind  = KIND_DOWN;
        n_ev0_rep   = 1'b0;
        n_ev_n      = 2'd0;
        rc1         = r_rep_cnt;
        frt1        = r_frt;
        delta       = '0;
        fire        = 1'b0;
        up          = 1'b0;
        kd1         = r_kd;
        case (r_in.cmd)
            CMD_FRAME: begin
                if (r_mode != MODE_RCA) begin
                    if (r_in.repeat_bit) begin
                        rc1 = (r_rep_cnt == 2'd3) ? r_rep_cnt : r_rep_cnt + 2'd1;
                        if (rc1 == 2'd1) begin
                            frt1 = r_tick;
                        end
                        delta = r_tick - frt1;
                    end else begin
                        rc1 = 2'd0;
                    end
                    n_frt     = frt1;
                    n_rep_cnt = rc1;
                    fire      = (rc1 == 2'd0) || (delta >= {16'd0, r_hold});
                    if (fire) begin
                        n_ev_n    = 2'd1;
                        n_kd      = 1'b1;
                        n_rep_cnt = 2'd0;
                        if (rc1 != 2'd0) begin
                            n_ev0_word = r_held;
                            n_ev0_rep  = 1'b1;
                        end else begin
                            n_held = r_in.frame_word;
                        end
                    end
                end else begin
                    up  = (r_held != 32'd0) && (r_held != r_in.frame_word);
                    kd1 = up ? 1'b0 : r_kd;
                    n_ev_n = {1'b0, up} + {1'b0, ~kd1};
                    if (up) begin
                        n_ev0_word = r_held;
                        n_ev0_kind = KIND_UP;
                    end
                    n_kd        = 1'b1;
                    n_held      = kd1 ? r_held : r_in.frame_word;
                    n_rel_cnt   = r_rdelay;
                    n_rel_armed = 1'b1;
                end
            end
            CMD_TICK: begin
                n_tick = r_tick + 32'd1;
                if (r_rel_armed) begin
                    if (r_rel_cnt <= 8'd1) begin
                        n_rel_armed = 1'b0;
                        n_rel_cnt   = 8'd0;
                        n_held      = '0;
                        if (r_kd) begin
                            n_ev_n     = 2'd1;
                            n_ev0_word = r_held;
                            n_ev0_kind = KIND_UP;
                            n_kd       = 1'b0;
                        end
                    end else begin
                        n_rel_cnt = r_rel_cnt - 8'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_rep_cnt   <= '0;
            r_frt       <= '0;
            r_held      <= '0;
            r_kd        <= 1'b0;
            r_rel_cnt   <= '0;
            r_rel_armed <= 1'b0;
            r_ev_n      <= '0;
            r_ev_sel    <= 1'b0;
        end else begin
            if (i_cmd.decide) begin
                r_tick      <= n_tick;
                r_rep_cnt   <= n_rep_cnt;
                r_frt       <= n_frt;
                r_held      <= n_held;
                r_kd        <= n_kd;
                r_rel_cnt   <= n_rel_cnt;
                r_rel_armed <= n_rel_armed;
                r_ev_n      <= n_ev_n;
                r_ev_sel    <= 1'b0;
            end else if (i_cmd.next_event) begin
                r_ev_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_ev0_word <= n_ev0_word;
            r_ev0_kind <= n_ev0_kind;
            r_ev0_rep  <= n_ev0_rep;
            r_ev1_word <= r_in.frame_word;
        end
    end

    // Field layout of the event being worked on.
    assign cur_word = r_ev_sel ? r_ev1_word : r_ev0_word;
    assign cur_kind = r_ev_sel ? KIND_DOWN : r_ev0_kind;
    assign cur_rep  = r_ev_sel ? 1'b0 : r_ev0_rep;

    always_comb begin
        case (r_mode)
            MODE_RCA: begin
                cur_cust = {12'd0, cur_word[11:8]};
                cur_scan = cur_word[7:0];
            end
            MODE_TOSHIBA: begin
                cur_cust = cur_word[31:16];
                cur_scan = cur_word[15:8];
            end
            default: begin
                cur_cust = cur_word[15:0];
                cur_scan = cur_word[23:16];
            end
        endcase
    end

    assign cust_match = (cur_cust == r_cust);

    // Key map write and one registered read a cycle.
    assign map_we = i_cmd.decide && (r_in.cmd == CMD_MAP_WR)
                    && ({3'd0, r_in.map_index} < DEPTH_LIM);
    assign rd_en  = i_cmd.search_step && !r_issue_done;

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_mem[AW'(r_in.map_index)] <= {r_in.map_scan, r_in.map_key};
        end
        if (rd_en) begin
            r_rd_word <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
        end else if (map_we) begin
            r_map_vld[AW'(r_in.map_index)] <= 1'b1;
        end
    end

    assign match = r_pipe && r_rd_vld && cust_match && (r_rd_word[23:16] == cur_scan);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_pipe       <= 1'b0;
            r_pipe_last  <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_res_hit    <= 1'b0;
            r_res_key    <= '0;
        end else if (i_cmd.search_start) begin
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_pipe       <= 1'b0;
            r_pipe_last  <= 1'b0;
            r_res_hit    <= 1'b0;
            r_res_key    <= '0;
        end else if (i_cmd.search_step) begin
            r_pipe <= rd_en;
            if (rd_en) begin
                r_rd_vld    <= r_map_vld[r_addr];
                r_pipe_last <= (r_addr == LAST_ADDR);
                if (r_addr == LAST_ADDR) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_addr <= r_addr + AW'(1);
                end
            end
            if (match) begin
                r_res_hit <= 1'b1;
                r_res_key <= r_rd_word[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.event_kind     <= cur_kind;
            r_out.customer_field <= cur_cust;
            r_out.scan_field     <= cur_scan;
            r_out.mapped_key     <= r_res_key;
            r_out.mapped_valid   <= r_res_hit;
            r_out.repeat_flag    <= cur_rep;
            r_out.last_of_run    <= r_ev_sel || (r_ev_n == 2'd1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_status.ev_count    = n_ev_n;
    assign o_status.search_done = !cust_match || match || (r_pipe && r_pipe_last);
    assign o_status.has_more    = !r_ev_sel && (r_ev_n == 2'd2);
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    a_miss_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.mapped_valid |-> r_out.mapped_key == 16'd0)
        else $error("mapped key is non-zero on a miss");

    a_repeat_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.repeat_flag |-> r_out.event_kind == KIND_DOWN)
        else $error("repeat flag set on a key-up");

    a_second_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_sel |-> r_ev_n == 2'd2)
        else $error("second event selected without two pending events");

    a_hit_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.search_step && match |=> r_res_hit)
        else $error("map hit not recorded");

endmodule

// File: rtl/ir_remote_key_event_tracker.sv
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   i_in_data   (irk_pkg::t_in_item)
// out      output     o_out_valid / i_out_ready o_out_data  (irk_pkg::t_out_item)
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An item is registered on capture, and its effect on the tracking state is settled in the
// next cycle. Each result then searches the key map one entry a cycle through the single
// read port of the map memory; the search ends at the first hit, after the last entry, or
// at once when the customer code does not match. An item yields no result, one or two.
// Reset is synchronous and active low; it clears the map valid bits at once, so no clearing
// pass is needed. A result waits in the output register while the next item is taken in;
// a stalled output holds back the following result and, while it waits, any further item.
module ir_remote_key_event_tracker #(
    parameter int MAP_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  irk_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output irk_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import irk_pkg::*;

    // The controller sequences each item through capture and decision, and each result through
    // map search and emission; the datapath holds the configuration, the key map and the tracking state.
    t_ctrl_cmd  cmd;
    t_dp_status status;

    irk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    irk_dp #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
